// ===== rtl/tbbm_pkg.sv =====
// shared widths, op codes and item types for the transformed box bounds merger
package tbbm_pkg;

	localparam int unsigned W      = 32;
	localparam int unsigned FRAC   = 16;
	localparam int unsigned PRODW  = 2 * W;
	localparam int unsigned SUMW   = PRODW + 2;
	localparam int unsigned AXES   = 3;
	localparam int unsigned MROWS  = 4;
	localparam int unsigned QDEPTH = 4;

	localparam logic [W-1:0] ONE_Q16 = 32'h0001_0000;

	// item kinds as they arrive on the input channel
	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_MERGE = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;
	localparam logic [1:0] KIND_NONE  = 2'd3;

	// classified operations carried through the back end
	localparam logic [1:0] OP_NOP   = 2'd0;
	localparam logic [1:0] OP_LOAD  = 2'd1;
	localparam logic [1:0] OP_MERGE = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	typedef logic [AXES-1:0][W-1:0] vec_t;

	typedef struct packed {
		logic [1:0] op;
		logic [1:0] row;
		vec_t       lo;
		vec_t       hi;
	} op_t;

	typedef struct packed {
		logic       vld;
		logic [1:0] op;
		vec_t       wmin;
		vec_t       wmax;
	} res_t;

endpackage

// ===== rtl/transformed_box_bounds_merger_unit.sv =====
// top level of the transformed box bounds merger
//
// Input channel (in_valid/in_ready): kind 0 loads transform row `row` from
// lo_x/lo_y/lo_z (row 3 is the translation), kind 1 merges the box given by
// the lo and hi corners, kind 2 clears the bounds, kind 3 changes nothing.
// Output channel (out_valid/out_ready): one item per input item, in order,
// showing have_bounds and the running world min and max after that item.
// Values are signed Q16.16; transformed corners saturate to 32 bits.
// An accepted item passes in order through the queue, product, sum, round
// and merge stages before it reaches the output.
// Throughput: one item per cycle unless out_ready stalls; eighteen 32x32
// multipliers in the product stage and the merge stage's bounds update allow it.
// Reset: transform returns to identity with zero translation, bounds to zero,
// have_bounds to 0, queue and pipeline empty.
// While out_ready is low with a result waiting, the back end holds; the
// front queue keeps taking items until it is full, then drops in_ready.
module transformed_box_bounds_merger_unit #(
	parameter int unsigned QDEPTH = tbbm_pkg::QDEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          kind,
	input  logic [1:0]          row,
	input  logic signed [31:0]  lo_x,
	input  logic signed [31:0]  lo_y,
	input  logic signed [31:0]  lo_z,
	input  logic signed [31:0]  hi_x,
	input  logic signed [31:0]  hi_y,
	input  logic signed [31:0]  hi_z,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                have_bounds,
	output logic signed [31:0]  out_min_x,
	output logic signed [31:0]  out_min_y,
	output logic signed [31:0]  out_min_z,
	output logic signed [31:0]  out_max_x,
	output logic signed [31:0]  out_max_y,
	output logic signed [31:0]  out_max_z
);

	logic           q_valid;
	logic           q_ready;
	tbbm_pkg::op_t  q_head;
	logic           adv;
	tbbm_pkg::res_t res;

	// accept and classify
	tbbm_front #(
		.DEPTH (QDEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.kind     (kind),
		.row      (row),
		.lo_x     (lo_x),
		.lo_y     (lo_y),
		.lo_z     (lo_z),
		.hi_x     (hi_x),
		.hi_y     (hi_y),
		.hi_z     (hi_z),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_head   (q_head)
	);

	// transform corners
	tbbm_xform u_xform (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_head  (q_head),
		.adv     (adv),
		.res     (res)
	);

	// merge into running bounds
	tbbm_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.res         (res),
		.adv         (adv),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.have_bounds (have_bounds),
		.out_min_x   (out_min_x),
		.out_min_y   (out_min_y),
		.out_min_z   (out_min_z),
		.out_max_x   (out_max_x),
		.out_max_y   (out_max_y),
		.out_max_z   (out_max_z)
	);

endmodule

// ===== rtl/tbbm_front.sv =====
// front end: accepts items, classifies them and queues them for the back end
module tbbm_front #(
	parameter int unsigned DEPTH = tbbm_pkg::QDEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          kind,
	input  logic [1:0]          row,
	input  logic signed [31:0]  lo_x,
	input  logic signed [31:0]  lo_y,
	input  logic signed [31:0]  lo_z,
	input  logic signed [31:0]  hi_x,
	input  logic signed [31:0]  hi_y,
	input  logic signed [31:0]  hi_z,
	output logic                q_valid,
	input  logic                q_ready,
	output tbbm_pkg::op_t       q_head
);

	localparam int unsigned PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNTW = $clog2(DEPTH + 1);

	tbbm_pkg::op_t    in_item;
	tbbm_pkg::op_t    mem_q [DEPTH];
	logic [PTRW-1:0]  wr_ptr_q;
	logic [PTRW-1:0]  rd_ptr_q;
	logic [CNTW-1:0]  cnt_q;
	logic             push;
	logic             pop;

	function automatic logic [PTRW-1:0] ptr_inc(input logic [PTRW-1:0] p);
		return (p == PTRW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// classify the incoming item, dropping fields its kind ignores
	always_comb begin
		in_item     = '0;
		in_item.lo  = {lo_z, lo_y, lo_x};
		in_item.hi  = {hi_z, hi_y, hi_x};
		unique case (kind)
			tbbm_pkg::KIND_LOAD: begin
				in_item.op  = tbbm_pkg::OP_LOAD;
				in_item.row = row;
				in_item.hi  = '0;
			end
			tbbm_pkg::KIND_MERGE: begin
				in_item.op = tbbm_pkg::OP_MERGE;
			end
			tbbm_pkg::KIND_CLEAR: begin
				in_item.op = tbbm_pkg::OP_CLEAR;
				in_item.lo = '0;
				in_item.hi = '0;
			end
			tbbm_pkg::KIND_NONE: begin
				in_item.op = tbbm_pkg::OP_NOP;
				in_item.lo = '0;
				in_item.hi = '0;
			end
		endcase
	end

	// queue handshakes
	assign in_ready = (cnt_q != CNTW'(DEPTH));
	assign q_valid  = (cnt_q != '0);
	assign push     = in_valid && in_ready;
	assign pop      = q_ready && q_valid;
	assign q_head   = mem_q[rd_ptr_q];

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
			cnt_q <= cnt_q + CNTW'(push) - CNTW'(pop);
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= in_item;
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNTW'(DEPTH))
		else $error("queue count above depth");

endmodule

// ===== rtl/tbbm_xform.sv =====
// back end transform pipeline: holds the matrix and turns box items into world extents
module tbbm_xform (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	output logic           q_ready,
	input  tbbm_pkg::op_t  q_head,
	input  logic           adv,
	output tbbm_pkg::res_t res
);

	localparam int unsigned W     = tbbm_pkg::W;
	localparam int unsigned AXES  = tbbm_pkg::AXES;
	localparam int unsigned PRODW = tbbm_pkg::PRODW;
	localparam int unsigned SUMW  = tbbm_pkg::SUMW;
	localparam int unsigned FRAC  = tbbm_pkg::FRAC;
	localparam int unsigned RW    = SUMW - FRAC + 1;
	localparam logic [SUMW-1:0] HALF = SUMW'(1) << (FRAC - 1);

	// matrix: rows 0..2 linear part, row 3 translation
	logic [tbbm_pkg::MROWS-1:0][AXES-1:0][W-1:0] mat_q;

	logic                    vld_s1;
	tbbm_pkg::op_t           item_s1;

	logic                    vld_s2;
	logic [1:0]              op_s2;
	logic signed [PRODW-1:0] plo_s2 [AXES][AXES];
	logic signed [PRODW-1:0] phi_s2 [AXES][AXES];
	tbbm_pkg::vec_t          t_s2;

	logic                    vld_s3;
	logic [1:0]              op_s3;
	logic signed [SUMW-1:0]  pmin_s3 [AXES];
	logic signed [SUMW-1:0]  pmax_s3 [AXES];
	tbbm_pkg::vec_t          t_s3;

	logic                    vld_s4;
	logic [1:0]              op_s4;
	tbbm_pkg::vec_t          wmin_s4;
	tbbm_pkg::vec_t          wmax_s4;

	logic signed [PRODW-1:0] plo [AXES][AXES];
	logic signed [PRODW-1:0] phi [AXES][AXES];
	logic signed [SUMW-1:0]  pmin [AXES];
	logic signed [SUMW-1:0]  pmax [AXES];
	tbbm_pkg::vec_t          wmin;
	tbbm_pkg::vec_t          wmax;

	function automatic logic [W-1:0] sat_q16(input logic signed [RW-1:0] v);
		logic [RW-W:0] top;
		top = v[RW-1:W-1];
		if (top == '0 || top == '1)
			return v[W-1:0];
		return v[RW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
	endfunction

	// round the Q34.32 sum to Q16.16, ties up, add translation, saturate
	function automatic logic [W-1:0] place(input logic signed [SUMW-1:0] p,
		input logic [W-1:0] t);
		logic signed [SUMW-1:0] r;
		logic signed [RW-1:0]   v;
		r = p + HALF;
		v = $signed({r[SUMW-1], r[SUMW-1:FRAC]}) + RW'($signed(t));
		return sat_q16(v);
	endfunction

	assign q_ready = adv;

	// stage valid flags: stage 1 captures from the queue, each later stage from the one before
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= q_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// matrix row load, applied in order at stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < tbbm_pkg::MROWS; r++)
				for (int c = 0; c < AXES; c++)
					mat_q[r][c] <= (r == c) ? tbbm_pkg::ONE_Q16 : '0;
		end else if (adv && vld_s1 && item_s1.op == tbbm_pkg::OP_LOAD) begin
			mat_q[item_s1.row] <= item_s1.lo;
		end
	end

	// products of both corner values with each matrix element
	always_comb begin
		for (int r = 0; r < AXES; r++) begin
			for (int c = 0; c < AXES; c++) begin
				plo[r][c] = $signed(PRODW'($signed(item_s1.lo[r])))
					* $signed(PRODW'($signed(mat_q[r][c])));
				phi[r][c] = $signed(PRODW'($signed(item_s1.hi[r])))
					* $signed(PRODW'($signed(mat_q[r][c])));
			end
		end
	end

	// per-axis min and max of the eight corner sums
	always_comb begin
		for (int c = 0; c < AXES; c++) begin
			pmin[c] = '0;
			pmax[c] = '0;
			for (int r = 0; r < AXES; r++) begin
				if (plo_s2[r][c] < phi_s2[r][c]) begin
					pmin[c] = pmin[c] + SUMW'(plo_s2[r][c]);
					pmax[c] = pmax[c] + SUMW'(phi_s2[r][c]);
				end else begin
					pmin[c] = pmin[c] + SUMW'(phi_s2[r][c]);
					pmax[c] = pmax[c] + SUMW'(plo_s2[r][c]);
				end
			end
		end
	end

	// rounding, translation and saturation
	always_comb begin
		for (int c = 0; c < AXES; c++) begin
			wmin[c] = place(pmin_s3[c], t_s3[c]);
			wmax[c] = place(pmax_s3[c], t_s3[c]);
		end
	end

	// stage payload registers
	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= q_head;
			op_s2   <= item_s1.op;
			plo_s2  <= plo;
			phi_s2  <= phi;
			t_s2    <= mat_q[tbbm_pkg::MROWS-1];
			op_s3   <= op_s2;
			pmin_s3 <= pmin;
			pmax_s3 <= pmax;
			t_s3    <= t_s2;
			op_s4   <= op_s3;
			wmin_s4 <= wmin;
			wmax_s4 <= wmax;
		end
	end

	assign res.vld  = vld_s4;
	assign res.op   = op_s4;
	assign res.wmin = wmin_s4;
	assign res.wmax = wmax_s4;

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s1) && $stable(vld_s2) && $stable(vld_s3) && $stable(vld_s4))
		else $error("pipeline moved while stalled");

	a_row_load: assert property (@(posedge clk) disable iff (!arst_n)
		adv && vld_s1 && item_s1.op == tbbm_pkg::OP_LOAD
		|=> mat_q[$past(item_s1.row)] == $past(item_s1.lo))
		else $error("matrix row not written by load item");

endmodule

// ===== rtl/tbbm_merge.sv =====
// back end merge stage: running bounds and the result register
module tbbm_merge (
	input  logic                clk,
	input  logic                arst_n,
	input  tbbm_pkg::res_t      res,
	output logic                adv,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                have_bounds,
	output logic signed [31:0]  out_min_x,
	output logic signed [31:0]  out_min_y,
	output logic signed [31:0]  out_min_z,
	output logic signed [31:0]  out_max_x,
	output logic signed [31:0]  out_max_y,
	output logic signed [31:0]  out_max_z
);

	localparam int unsigned AXES = tbbm_pkg::AXES;

	logic           out_valid_q;
	logic           started_q;
	tbbm_pkg::vec_t min_q;
	tbbm_pkg::vec_t max_q;

	// the pipeline moves whenever the result slot is free or being taken
	assign adv = !out_valid_q || out_ready;

	// bounds update as the item enters the result slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			started_q   <= 1'b0;
			min_q       <= '0;
			max_q       <= '0;
		end else if (adv) begin
			out_valid_q <= res.vld;
			if (res.vld) begin
				case (res.op)
					tbbm_pkg::OP_MERGE: begin
						for (int c = 0; c < AXES; c++) begin
							if (!started_q || $signed(res.wmin[c]) < $signed(min_q[c]))
								min_q[c] <= res.wmin[c];
							if (!started_q || $signed(res.wmax[c]) > $signed(max_q[c]))
								max_q[c] <= res.wmax[c];
						end
						started_q <= 1'b1;
					end
					tbbm_pkg::OP_CLEAR: begin
						min_q     <= '0;
						max_q     <= '0;
						started_q <= 1'b0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign have_bounds = started_q;
	assign out_min_x   = min_q[0];
	assign out_min_y   = min_q[1];
	assign out_min_z   = min_q[2];
	assign out_max_x   = max_q[0];
	assign out_max_y   = max_q[1];
	assign out_max_z   = max_q[2];

	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		started_q |-> $signed(min_q[0]) <= $signed(max_q[0])
			&& $signed(min_q[1]) <= $signed(max_q[1])
			&& $signed(min_q[2]) <= $signed(max_q[2]))
		else $error("running min above running max");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!started_q |-> min_q == '0 && max_q == '0)
		else $error("bounds not zero while empty");

endmodule
